// ===== design/boris_particle_push_rz_top_macros.svh =====
// Assertion macros shared by the particle push checker.
`ifndef BORIS_PARTICLE_PUSH_RZ_TOP_MACROS_SVH
`define BORIS_PARTICLE_PUSH_RZ_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define BPPRZ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define BPPRZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bpprz_pkg.sv =====
// Types, constants and saturating fixed-point helpers for the RZ particle push.
package bpprz_pkg;

  localparam int unsigned DW = 32;
  localparam int unsigned FB = 16;

  localparam int unsigned DIV_STAGES  = 16;
  localparam int unsigned DIV_LAT     = DIV_STAGES + 2;
  localparam int unsigned SQRT_STAGES = 16;
  localparam int unsigned SQRT_LAT    = SQRT_STAGES + 1;
  localparam int unsigned PIPE_LAT    = 4 + DIV_LAT + 7 + SQRT_LAT + DIV_LAT + 3;

  typedef logic signed [DW-1:0] fix_t;

  localparam fix_t FIX_MAX = 32'sh7FFF_FFFF;
  localparam fix_t FIX_MIN = 32'sh8000_0000;
  localparam fix_t FIX_ONE = 32'sh0001_0000;

  localparam logic [30:0] DT_RST   = 31'd65536;
  localparam logic [31:0] QM_RST   = 32'd65536;
  localparam logic [30:0] AXIS_RST = 31'd0;

  typedef enum logic [1:0] {
    CFG_TIME_STEP        = 2'd0,
    CFG_CHARGE_OVER_MASS = 2'd1,
    CFG_AXIS_RADIUS      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    fix_t pos_z;
    fix_t pos_r;
    fix_t vel_z;
    fix_t vel_r;
    fix_t vel_y;
    fix_t field_ez;
    fix_t field_er;
    fix_t field_bz;
    fix_t field_br;
    logic last_particle;
  } in_t;

  typedef struct packed {
    fix_t new_pos_z;
    fix_t new_pos_r;
    fix_t new_vel_z;
    fix_t new_vel_r;
    fix_t new_vel_y;
    logic end_of_batch;
  } out_t;

  function automatic fix_t sadd(fix_t a, fix_t b);
    logic signed [DW:0] s;
    s = (DW+1)'(a) + (DW+1)'(b);
    if (s[DW] != s[DW-1]) begin
      sadd = s[DW] ? FIX_MIN : FIX_MAX;
    end else begin
      sadd = s[DW-1:0];
    end
  endfunction

  function automatic fix_t ssub(fix_t a, fix_t b);
    logic signed [DW:0] s;
    s = (DW+1)'(a) - (DW+1)'(b);
    if (s[DW] != s[DW-1]) begin
      ssub = s[DW] ? FIX_MIN : FIX_MAX;
    end else begin
      ssub = s[DW-1:0];
    end
  endfunction

  // Magnitude of a signed word; the most negative value maps to 2^31.
  function automatic logic [DW-1:0] magn(fix_t a);
    logic [DW:0] n;
    n = (DW+1)'(0) - (DW+1)'(a);
    magn = a[DW-1] ? n[DW-1:0] : a;
  endfunction

  // Signed limit and negate for a magnitude that may overflow.
  function automatic fix_t pack(logic neg, logic ovf, logic [DW-1:0] m);
    logic [DW-1:0] lim;
    logic [DW-1:0] v;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    v = (ovf || (m > lim)) ? lim : m;
    pack = neg ? fix_t'(~v + 32'd1) : fix_t'(v);
  endfunction

  // Q16.16 product, magnitude truncated, saturated.
  function automatic fix_t fmul(fix_t a, fix_t b);
    logic [DW-1:0]   ma;
    logic [DW-1:0]   mb;
    logic [2*DW-1:0] p;
    ma = magn(a);
    mb = magn(b);
    p = (2*DW)'(ma) * (2*DW)'(mb);
    fmul = pack(a[DW-1] ^ b[DW-1], |p[2*DW-1:DW+FB], p[DW+FB-1:FB]);
  endfunction

endpackage

// ===== design/bpprz_div.sv =====
// Pipelined Q16.16 divider, two quotient bits per stage.
module bpprz_div (
  input  logic              clk_i,
  input  bpprz_pkg::fix_t   num_i,
  input  bpprz_pkg::fix_t   den_i,
  output bpprz_pkg::fix_t   quo_o
);

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
    logic [31:0] den;
    logic        neg;
    logic        ovf;
  } div_st_t;

  div_st_t         st_q [bpprz_pkg::DIV_STAGES+1];
  div_st_t         prep_d;
  bpprz_pkg::fix_t quo_q;
  logic [31:0]     mn;
  logic [31:0]     md;

  function automatic div_st_t dstep(div_st_t s);
    div_st_t     r;
    logic [32:0] t;
    r = s;
    t = {s.rem[31:0], s.low[31]};
    r.low = {s.low[30:0], 1'b0};
    if (t >= {1'b0, s.den}) begin
      r.rem = t - {1'b0, s.den};
      r.quo = {s.quo[30:0], 1'b1};
    end else begin
      r.rem = t;
      r.quo = {s.quo[30:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    mn = bpprz_pkg::magn(num_i);
    md = bpprz_pkg::magn(den_i);
    prep_d.rem = {17'd0, mn[31:16]};
    prep_d.low = {mn[15:0], 16'd0};
    prep_d.quo = '0;
    prep_d.den = md;
    prep_d.neg = num_i[31] ^ den_i[31];
    // quotient of 2^32 or more saturates anyway
    prep_d.ovf = {16'd0, mn[31:16]} >= md;
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= prep_d;
    for (int i = 1; i <= bpprz_pkg::DIV_STAGES; i++) begin
      st_q[i] <= dstep(dstep(st_q[i-1]));
    end
    quo_q <= bpprz_pkg::pack(st_q[bpprz_pkg::DIV_STAGES].neg,
                             st_q[bpprz_pkg::DIV_STAGES].ovf,
                             st_q[bpprz_pkg::DIV_STAGES].quo);
  end

  assign quo_o = quo_q;

endmodule

// ===== design/bpprz_sqrt.sv =====
// Pipelined integer square root of a 64-bit radicand, two root bits per stage.
module bpprz_sqrt (
  input  logic            clk_i,
  input  logic [63:0]     rad_i,
  output bpprz_pkg::fix_t root_o
);

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_st_t;

  sq_st_t          st_q [bpprz_pkg::SQRT_STAGES];
  sq_st_t          init_d;
  bpprz_pkg::fix_t root_q;

  function automatic sq_st_t sstep(sq_st_t s);
    sq_st_t      r;
    logic [34:0] x;
    logic [34:0] t;
    x = {s.rem[32:0], s.rad[63:62]};
    t = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[61:0], 2'b00};
    if (x >= t) begin
      r.rem  = x - t;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = x;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  assign init_d = '{rem: '0, root: '0, rad: rad_i};

  always_ff @(posedge clk_i) begin
    st_q[0] <= sstep(sstep(init_d));
    for (int i = 1; i < bpprz_pkg::SQRT_STAGES; i++) begin
      st_q[i] <= sstep(sstep(st_q[i-1]));
    end
    root_q <= st_q[bpprz_pkg::SQRT_STAGES-1].root[31] ? bpprz_pkg::FIX_MAX
              : bpprz_pkg::fix_t'(st_q[bpprz_pkg::SQRT_STAGES-1].root);
  end

  assign root_o = root_q;

endmodule

// ===== design/boris_particle_push_rz_top.sv =====
// Boris particle push in RZ geometry, signed Q16.16, fully pipelined.
//
// Usage:
//   Drive a particle word on item_i and raise start_i; the word is taken at
//   each rising edge where start_i is high and busy_o is low. A new particle
//   may be taken every cycle: one particle per clock sustained.
//   Each result word appears on result_o for exactly one cycle, marked by
//   result_valid_o, in the order its particles were taken. The receiver
//   cannot stall; nothing here ever holds a result. The pipeline is a chain:
//   field kicks and |t|^2 (4 stages), the divider for s (18), the push and
//   position update (7), the square root for r (17), the divider for sin
//   and cos (18) and the final rotation (3).
//   Configuration (time step, q/m, axis radius) is written through the
//   cfg_valid_i / cfg_ready_o channel, always ready; write only while the
//   pipeline is empty.
//   Reset is asynchronous, active low: it clears the valid bits, loads the
//   register defaults and keeps busy_o high until the clock after release.
module boris_particle_push_rz_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  bpprz_pkg::in_t      item_i,
  output logic                result_valid_o,
  output bpprz_pkg::out_t     result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  typedef bpprz_pkg::fix_t fix_t;

  typedef struct packed {
    fix_t pz, pr, vz, vr, vy, kez, ker, t0, t1;
    logic last;
  } p1_t;

  typedef struct packed {
    fix_t pz, pr, vy, m0, m1, kez, ker, t0, t1, sq0, sq1, tt0, tt1;
    logic last;
  } p2_t;

  // carried past the first divider
  typedef struct packed {
    fix_t pz, pr, vy, m0, m1, kez, ker, a, b, c, d;
    logic last;
  } da_t;

  typedef struct packed {
    da_t  cw;
    fix_t den, tt0, tt1;
  } p3_t;

  typedef struct packed {
    fix_t pz, pr, vy, m0, m1, kez, ker, p0, p1, p2, s0, s1;
    logic last;
  } q1_t;

  typedef struct packed {
    fix_t pz, pr, vy, m0, m1, kez, ker, e, f, g, h;
    logic last;
  } q2_t;

  typedef struct packed {
    fix_t pz, pr, vz, vr, vy;
    logic last;
  } q3_t;

  typedef struct packed {
    fix_t pz, pr, vz, vr, vy, dz, dr, py;
    logic last;
  } q4_t;

  typedef struct packed {
    fix_t pz, pr, py, vz, vr, vy;
    logic last;
  } q5_t;

  typedef struct packed {
    q5_t         cw;
    logic [63:0] sqr, sqy;
  } q6_t;

  // carried past the second divider
  typedef struct packed {
    fix_t pz, rr, vz, vr, vy;
    logic near;
    logic last;
  } rc_t;

  typedef struct packed {
    fix_t pz, rr, vz, vr, vy, sn, cs;
    logic last;
  } r2_t;

  typedef struct packed {
    fix_t pz, rr, vz, a, b, c, d;
    logic last;
  } r3_t;

  // Control and configuration
  logic        busy_q;
  logic        accept;
  logic [bpprz_pkg::PIPE_LAT-1:0] vld_q;
  logic [30:0] dt_q;
  logic [31:0] qm_q;
  logic [30:0] axis_q;
  fix_t        k_q;
  fix_t        dt_fix;

  // Payload pipeline
  bpprz_pkg::in_t  it_q;
  p1_t             p1_q;
  p2_t             p2_q;
  p3_t             p3_q;
  da_t             dla_q [bpprz_pkg::DIV_LAT];
  fix_t            s0, s1;
  q1_t             q1_q;
  q2_t             q2_q;
  q3_t             q3_q;
  q4_t             q4_q;
  q5_t             q5_q;
  q6_t             q6_q;
  q5_t             q7_q;
  logic [63:0]     x_q;
  q5_t             dlb_q [bpprz_pkg::SQRT_LAT];
  fix_t            rr;
  rc_t             rc_d;
  rc_t             dlc_q [bpprz_pkg::DIV_LAT];
  fix_t            sn_div, cs_div;
  r2_t             r2_q;
  r3_t             r3_q;
  bpprz_pkg::out_t res_q;
  logic [31:0]     mpr, mpy;

  assign accept      = start_i & ~busy_q;
  assign busy_o      = busy_q;
  assign cfg_ready_o = 1'b1;
  assign dt_fix      = fix_t'({1'b0, dt_q});

  // Busy clears at the clock after reset; then take a word every cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      vld_q  <= '0;
    end else begin
      busy_q <= 1'b0;
      vld_q  <= {vld_q[bpprz_pkg::PIPE_LAT-2:0], accept};
    end
  end

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q   <= bpprz_pkg::DT_RST;
      qm_q   <= bpprz_pkg::QM_RST;
      axis_q <= bpprz_pkg::AXIS_RST;
    end else if (cfg_valid_i) begin
      case (bpprz_pkg::cfg_idx_e'(cfg_index_i))
        bpprz_pkg::CFG_TIME_STEP:        dt_q   <= cfg_data_i[30:0];
        bpprz_pkg::CFG_CHARGE_OVER_MASS: qm_q   <= cfg_data_i;
        bpprz_pkg::CFG_AXIS_RADIUS:      axis_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // k = (q/m) * dt/2, refreshed every cycle from the registers
  always_ff @(posedge clk_i) begin
    k_q <= bpprz_pkg::fmul(fix_t'(qm_q), fix_t'({2'b00, dt_q[30:1]}));
  end

  // Front end: kicks, t, |t|^2 and cross terms of the rotation
  always_ff @(posedge clk_i) begin
    it_q <= item_i;

    p1_q.pz   <= it_q.pos_z;
    p1_q.pr   <= it_q.pos_r;
    p1_q.vz   <= it_q.vel_z;
    p1_q.vr   <= it_q.vel_r;
    p1_q.vy   <= it_q.vel_y;
    p1_q.kez  <= bpprz_pkg::fmul(k_q, it_q.field_ez);
    p1_q.ker  <= bpprz_pkg::fmul(k_q, it_q.field_er);
    p1_q.t0   <= bpprz_pkg::fmul(k_q, it_q.field_bz);
    p1_q.t1   <= bpprz_pkg::fmul(k_q, it_q.field_br);
    p1_q.last <= it_q.last_particle;

    p2_q.pz   <= p1_q.pz;
    p2_q.pr   <= p1_q.pr;
    p2_q.vy   <= p1_q.vy;
    p2_q.m0   <= bpprz_pkg::sadd(p1_q.vz, p1_q.kez);
    p2_q.m1   <= bpprz_pkg::sadd(p1_q.vr, p1_q.ker);
    p2_q.kez  <= p1_q.kez;
    p2_q.ker  <= p1_q.ker;
    p2_q.t0   <= p1_q.t0;
    p2_q.t1   <= p1_q.t1;
    p2_q.sq0  <= bpprz_pkg::fmul(p1_q.t0, p1_q.t0);
    p2_q.sq1  <= bpprz_pkg::fmul(p1_q.t1, p1_q.t1);
    p2_q.tt0  <= bpprz_pkg::sadd(p1_q.t0, p1_q.t0);
    p2_q.tt1  <= bpprz_pkg::sadd(p1_q.t1, p1_q.t1);
    p2_q.last <= p1_q.last;

    p3_q.cw.pz   <= p2_q.pz;
    p3_q.cw.pr   <= p2_q.pr;
    p3_q.cw.vy   <= p2_q.vy;
    p3_q.cw.m0   <= p2_q.m0;
    p3_q.cw.m1   <= p2_q.m1;
    p3_q.cw.kez  <= p2_q.kez;
    p3_q.cw.ker  <= p2_q.ker;
    p3_q.cw.a    <= bpprz_pkg::fmul(p2_q.vy, p2_q.t1);
    p3_q.cw.b    <= bpprz_pkg::fmul(p2_q.vy, p2_q.t0);
    p3_q.cw.c    <= bpprz_pkg::fmul(p2_q.m0, p2_q.t1);
    p3_q.cw.d    <= bpprz_pkg::fmul(p2_q.m1, p2_q.t0);
    p3_q.cw.last <= p2_q.last;
    p3_q.den     <= bpprz_pkg::sadd(bpprz_pkg::FIX_ONE,
                                    bpprz_pkg::sadd(p2_q.sq0, p2_q.sq1));
    p3_q.tt0     <= p2_q.tt0;
    p3_q.tt1     <= p2_q.tt1;
  end

  // s = 2t / (1 + |t|^2); den is at least one, so never zero
  bpprz_div u_div_s0 (.clk_i(clk_i), .num_i(p3_q.tt0), .den_i(p3_q.den), .quo_o(s0));
  bpprz_div u_div_s1 (.clk_i(clk_i), .num_i(p3_q.tt1), .den_i(p3_q.den), .quo_o(s1));

  // Advance the carried terms alongside the divider.
  always_ff @(posedge clk_i) begin
    dla_q[0] <= p3_q.cw;
    for (int i = 1; i < bpprz_pkg::DIV_LAT; i++) begin
      dla_q[i] <= dla_q[i-1];
    end
  end

  // Rotation, second half kick, position update and the squared radius
  always_ff @(posedge clk_i) begin
    q1_q.pz   <= dla_q[bpprz_pkg::DIV_LAT-1].pz;
    q1_q.pr   <= dla_q[bpprz_pkg::DIV_LAT-1].pr;
    q1_q.vy   <= dla_q[bpprz_pkg::DIV_LAT-1].vy;
    q1_q.m0   <= dla_q[bpprz_pkg::DIV_LAT-1].m0;
    q1_q.m1   <= dla_q[bpprz_pkg::DIV_LAT-1].m1;
    q1_q.kez  <= dla_q[bpprz_pkg::DIV_LAT-1].kez;
    q1_q.ker  <= dla_q[bpprz_pkg::DIV_LAT-1].ker;
    q1_q.p0   <= bpprz_pkg::ssub(dla_q[bpprz_pkg::DIV_LAT-1].m0,
                                 dla_q[bpprz_pkg::DIV_LAT-1].a);
    q1_q.p1   <= bpprz_pkg::sadd(dla_q[bpprz_pkg::DIV_LAT-1].m1,
                                 dla_q[bpprz_pkg::DIV_LAT-1].b);
    q1_q.p2   <= bpprz_pkg::sadd(dla_q[bpprz_pkg::DIV_LAT-1].vy,
                                 bpprz_pkg::ssub(dla_q[bpprz_pkg::DIV_LAT-1].c,
                                                 dla_q[bpprz_pkg::DIV_LAT-1].d));
    q1_q.s0   <= s0;
    q1_q.s1   <= s1;
    q1_q.last <= dla_q[bpprz_pkg::DIV_LAT-1].last;

    q2_q.pz   <= q1_q.pz;
    q2_q.pr   <= q1_q.pr;
    q2_q.vy   <= q1_q.vy;
    q2_q.m0   <= q1_q.m0;
    q2_q.m1   <= q1_q.m1;
    q2_q.kez  <= q1_q.kez;
    q2_q.ker  <= q1_q.ker;
    q2_q.e    <= bpprz_pkg::fmul(q1_q.p2, q1_q.s1);
    q2_q.f    <= bpprz_pkg::fmul(q1_q.p2, q1_q.s0);
    q2_q.g    <= bpprz_pkg::fmul(q1_q.p0, q1_q.s1);
    q2_q.h    <= bpprz_pkg::fmul(q1_q.p1, q1_q.s0);
    q2_q.last <= q1_q.last;

    q3_q.pz   <= q2_q.pz;
    q3_q.pr   <= q2_q.pr;
    q3_q.vz   <= bpprz_pkg::sadd(q2_q.m0, bpprz_pkg::ssub(q2_q.kez, q2_q.e));
    q3_q.vr   <= bpprz_pkg::sadd(bpprz_pkg::sadd(q2_q.m1, q2_q.f), q2_q.ker);
    q3_q.vy   <= bpprz_pkg::sadd(q2_q.vy, bpprz_pkg::ssub(q2_q.g, q2_q.h));
    q3_q.last <= q2_q.last;

    q4_q.pz   <= q3_q.pz;
    q4_q.pr   <= q3_q.pr;
    q4_q.vz   <= q3_q.vz;
    q4_q.vr   <= q3_q.vr;
    q4_q.vy   <= q3_q.vy;
    q4_q.dz   <= bpprz_pkg::fmul(q3_q.vz, dt_fix);
    q4_q.dr   <= bpprz_pkg::fmul(q3_q.vr, dt_fix);
    q4_q.py   <= bpprz_pkg::fmul(q3_q.vy, dt_fix);
    q4_q.last <= q3_q.last;

    q5_q.pz   <= bpprz_pkg::sadd(q4_q.pz, q4_q.dz);
    q5_q.pr   <= bpprz_pkg::sadd(q4_q.pr, q4_q.dr);
    q5_q.py   <= q4_q.py;
    q5_q.vz   <= q4_q.vz;
    q5_q.vr   <= q4_q.vr;
    q5_q.vy   <= q4_q.vy;
    q5_q.last <= q4_q.last;

    q6_q.cw  <= q5_q;
    q6_q.sqr <= 64'(mpr) * 64'(mpr);
    q6_q.sqy <= 64'(mpy) * 64'(mpy);

    q7_q <= q6_q.cw;
    x_q  <= q6_q.sqr + q6_q.sqy;
  end

  assign mpr = bpprz_pkg::magn(q5_q.pr);
  assign mpy = bpprz_pkg::magn(q5_q.py);

  // r = floor(sqrt(pr^2 + py^2))
  bpprz_sqrt u_sqrt (.clk_i(clk_i), .rad_i(x_q), .root_o(rr));

  always_ff @(posedge clk_i) begin
    dlb_q[0] <= q7_q;
    for (int i = 1; i < bpprz_pkg::SQRT_LAT; i++) begin
      dlb_q[i] <= dlb_q[i-1];
    end
  end

  // Near the axis (r not above the axis radius) the divider quotients are dropped.
  always_comb begin
    rc_d.pz   = dlb_q[bpprz_pkg::SQRT_LAT-1].pz;
    rc_d.rr   = rr;
    rc_d.vz   = dlb_q[bpprz_pkg::SQRT_LAT-1].vz;
    rc_d.vr   = dlb_q[bpprz_pkg::SQRT_LAT-1].vr;
    rc_d.vy   = dlb_q[bpprz_pkg::SQRT_LAT-1].vy;
    rc_d.near = !($unsigned(rr) > {1'b0, axis_q});
    rc_d.last = dlb_q[bpprz_pkg::SQRT_LAT-1].last;
  end

  bpprz_div u_div_sn (.clk_i(clk_i), .num_i(dlb_q[bpprz_pkg::SQRT_LAT-1].py),
                      .den_i(rr), .quo_o(sn_div));
  bpprz_div u_div_cs (.clk_i(clk_i), .num_i(dlb_q[bpprz_pkg::SQRT_LAT-1].pr),
                      .den_i(rr), .quo_o(cs_div));

  always_ff @(posedge clk_i) begin
    dlc_q[0] <= rc_d;
    for (int i = 1; i < bpprz_pkg::DIV_LAT; i++) begin
      dlc_q[i] <= dlc_q[i-1];
    end
  end

  // Rotate the velocity back into the RZ plane.
  always_ff @(posedge clk_i) begin
    r2_q.pz   <= dlc_q[bpprz_pkg::DIV_LAT-1].pz;
    r2_q.rr   <= dlc_q[bpprz_pkg::DIV_LAT-1].rr;
    r2_q.vz   <= dlc_q[bpprz_pkg::DIV_LAT-1].vz;
    r2_q.vr   <= dlc_q[bpprz_pkg::DIV_LAT-1].vr;
    r2_q.vy   <= dlc_q[bpprz_pkg::DIV_LAT-1].vy;
    r2_q.sn   <= dlc_q[bpprz_pkg::DIV_LAT-1].near ? '0 : sn_div;
    r2_q.cs   <= dlc_q[bpprz_pkg::DIV_LAT-1].near ? bpprz_pkg::FIX_ONE : cs_div;
    r2_q.last <= dlc_q[bpprz_pkg::DIV_LAT-1].last;

    r3_q.pz   <= r2_q.pz;
    r3_q.rr   <= r2_q.rr;
    r3_q.vz   <= r2_q.vz;
    r3_q.a    <= bpprz_pkg::fmul(r2_q.cs, r2_q.vr);
    r3_q.b    <= bpprz_pkg::fmul(r2_q.sn, r2_q.vy);
    r3_q.c    <= bpprz_pkg::fmul(r2_q.cs, r2_q.vy);
    r3_q.d    <= bpprz_pkg::fmul(r2_q.sn, r2_q.vr);
    r3_q.last <= r2_q.last;

    res_q.new_pos_z    <= r3_q.pz;
    res_q.new_pos_r    <= r3_q.rr;
    res_q.new_vel_z    <= r3_q.vz;
    res_q.new_vel_r    <= bpprz_pkg::sadd(r3_q.a, r3_q.b);
    res_q.new_vel_y    <= bpprz_pkg::ssub(r3_q.c, r3_q.d);
    res_q.end_of_batch <= r3_q.last;
  end

  assign result_valid_o = vld_q[bpprz_pkg::PIPE_LAT-1];
  assign result_o       = res_q;

endmodule

// ===== design/bpprz_checker.sv =====
// Port-level checker for the RZ particle push, bound to the top level.
`include "boris_particle_push_rz_top_macros.svh"

module bpprz_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_i,
  input bpprz_pkg::in_t  item_i,
  input logic            result_valid_i,
  input bpprz_pkg::out_t result_i
);

  `BPPRZ_ASSERT_IMPL(a_word_out, start_i && !busy_i, ##(bpprz_pkg::PIPE_LAT) result_valid_i, "taken word gave no result")
  `BPPRZ_ASSERT_IMPL(a_no_extra, result_valid_i, $past(start_i && !busy_i, bpprz_pkg::PIPE_LAT), "result without a taken word")
  `BPPRZ_ASSERT_IMPL(a_eob, result_valid_i, result_i.end_of_batch == $past(item_i.last_particle, bpprz_pkg::PIPE_LAT), "end of batch mark misplaced")
  `BPPRZ_ASSERT_NEXT(a_busy_rel, busy_i, !busy_i, "busy held after reset release")

endmodule

bind boris_particle_push_rz_top bpprz_checker u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_i         (busy_o),
  .item_i         (item_i),
  .result_valid_i (result_valid_o),
  .result_i       (result_o)
);

// ===== bench/tb_boris_particle_push_rz_top.sv =====
// Self-checking bench for the RZ Boris particle push: random and directed particles.
`timescale 1ns / 1ps

module tb_boris_particle_push_rz_top;

  typedef bpprz_pkg::fix_t fix_t;
  typedef bpprz_pkg::in_t  in_t;
  typedef bpprz_pkg::out_t out_t;

  localparam int unsigned LAT        = bpprz_pkg::PIPE_LAT;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned N_RANDOM   = 1750;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  in_t         item_i;
  logic        result_valid_o;
  out_t        result_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  boris_particle_push_rz_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Shadow copy of the block's registers, updated on each accepted write.
  logic [30:0] dt_q;
  logic [31:0] qm_q;
  logic [30:0] axis_q;

  in_t  particle_q[$];
  out_t pushed_q[$];
  int   errors;
  bit   quiet_send;   // disable random idling for a stretch
  int   hold_count;   // nonzero while the driver holds off

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic, 64-bit internal words clamped to 32 bits.
  // ---------------------------------------------------------------------------
  localparam longint P_MAX = 64'sd2147483647;
  localparam longint P_MIN = -64'sd2147483648;

  function automatic longint clamp_w(longint x);
    if (x > P_MAX) return P_MAX;
    if (x < P_MIN) return P_MIN;
    return x;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    return clamp_w(a + b);
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    return clamp_w(a - b);
  endfunction

  function automatic longint signed_limit(bit neg, logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (m > lim) m = lim;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic logic [63:0] abs_w(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] p;
    p = 128'(abs_w(a)) * 128'(abs_w(b));
    return signed_limit((a < 0) != (b < 0), p >> 16);
  endfunction

  function automatic longint q_div(longint a, longint d);
    logic [127:0] n;
    n = 128'(abs_w(a)) << 16;
    return signed_limit((a < 0) != (d < 0), n / 128'(abs_w(d)));
  endfunction

  function automatic longint radius_of(longint a, longint b);
    logic [127:0] x;
    logic [63:0]  res;
    logic [63:0]  c;
    x = 128'(abs_w(a)) * 128'(abs_w(a)) + 128'(abs_w(b)) * 128'(abs_w(b));
    res = '0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      c = res | (64'd1 << bit_i);
      if (128'(c) * 128'(c) <= x) res = c;
    end
    return res > 64'h7FFF_FFFF ? P_MAX : longint'(res);
  endfunction

  // Push one particle with the current register copy.
  function automatic out_t push_particle(in_t p);
    longint dt, qm, axis, pz, pr, vz, vr, vy, k, kez, ker, t0, t1, den;
    longint s0, s1, m0, m1, m2, p0, p1, p2, py, rr, sn, cs;
    out_t o;
    dt   = longint'(dt_q);
    qm   = longint'($signed(qm_q));
    axis = longint'(axis_q);
    pz = p.pos_z; pr = p.pos_r;
    vz = p.vel_z; vr = p.vel_r; vy = p.vel_y;
    k   = q_mul(qm, dt >>> 1);
    kez = q_mul(k, p.field_ez);
    ker = q_mul(k, p.field_er);
    t0  = q_mul(k, p.field_bz);
    t1  = q_mul(k, p.field_br);
    den = add_sat(65536, add_sat(q_mul(t0, t0), q_mul(t1, t1)));
    s0 = q_div(add_sat(t0, t0), den);
    s1 = q_div(add_sat(t1, t1), den);
    m0 = add_sat(vz, kez);
    m1 = add_sat(vr, ker);
    m2 = vy;
    p0 = sub_sat(m0, q_mul(m2, t1));
    p1 = add_sat(m1, q_mul(m2, t0));
    p2 = add_sat(m2, sub_sat(q_mul(m0, t1), q_mul(m1, t0)));
    vz = add_sat(m0, sub_sat(kez, q_mul(p2, s1)));
    vr = add_sat(add_sat(m1, q_mul(p2, s0)), ker);
    vy = add_sat(m2, sub_sat(q_mul(p0, s1), q_mul(p1, s0)));
    pz = add_sat(pz, q_mul(vz, dt));
    pr = add_sat(pr, q_mul(vr, dt));
    py = q_mul(vy, dt);
    rr = radius_of(pr, py);
    // near the axis: no rotation
    if (rr > axis) begin
      sn = q_div(py, rr);
      cs = q_div(pr, rr);
    end else begin
      sn = 0;
      cs = 65536;
    end
    o.new_pos_z    = fix_t'(pz);
    o.new_pos_r    = fix_t'(rr);
    o.new_vel_z    = fix_t'(vz);
    o.new_vel_r    = fix_t'(add_sat(q_mul(cs, vr), q_mul(sn, vy)));
    o.new_vel_y    = fix_t'(sub_sat(q_mul(cs, vy), q_mul(sn, vr)));
    o.end_of_batch = p.last_particle;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: take the head of the particle queue, idle at random.
  // Acceptance is sampled at the rising edge; the driver reacts at the fall.
  // ---------------------------------------------------------------------------
  logic taken;
  always @(posedge clk_i) begin
    taken <= start_i && !busy_o && rst_ni;
    if (start_i && !busy_o && rst_ni) begin
      pushed_q.push_back(push_particle(item_i));
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (taken) void'(particle_q.pop_front());
      if (hold_count > 0) begin
        start_i <= 1'b0;
      end else if (particle_q.size() > 0
                   && (quiet_send || $urandom_range(99) >= 25)) begin
        start_i <= 1'b1;
        item_i  <= particle_q[0];
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result word with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && result_valid_o) begin
      if (pushed_q.size() == 0) begin
        report_mismatch("unexpected result", result_o.new_pos_z, 32'd0);
      end else begin
        want = pushed_q.pop_front();
        if (result_o.new_pos_z !== want.new_pos_z)
          report_mismatch("new_pos_z", result_o.new_pos_z, want.new_pos_z);
        if (result_o.new_pos_r !== want.new_pos_r)
          report_mismatch("new_pos_r", result_o.new_pos_r, want.new_pos_r);
        if (result_o.new_vel_z !== want.new_vel_z)
          report_mismatch("new_vel_z", result_o.new_vel_z, want.new_vel_z);
        if (result_o.new_vel_r !== want.new_vel_r)
          report_mismatch("new_vel_r", result_o.new_vel_r, want.new_vel_r);
        if (result_o.new_vel_y !== want.new_vel_y)
          report_mismatch("new_vel_y", result_o.new_vel_y, want.new_vel_y);
        if (result_o.end_of_batch !== want.end_of_batch)
          report_mismatch("end_of_batch", 32'(result_o.end_of_batch),
                          32'(want.end_of_batch));
      end
    end
  end

  // Watchdog: cycles with nothing accepted in either direction.
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic fix_t rand_word();
    case ($urandom_range(5))
      0:       return fix_t'($urandom());
      1:       return fix_t'($urandom_range(2)) - 1
                      + (($urandom_range(1)) ? bpprz_pkg::FIX_MAX : bpprz_pkg::FIX_MIN);
      2:       return fix_t'(int'($urandom_range(2 * 65536)) - 65536);
      default: return fix_t'(int'($urandom_range(40 * 65536)) - 20 * 65536);
    endcase
  endfunction

  function automatic fix_t rand_field();
    if ($urandom_range(9) == 0) return fix_t'($urandom());
    return fix_t'(int'($urandom_range(4 * 65536)) - 2 * 65536);
  endfunction

  function automatic in_t rand_particle();
    in_t p;
    p.pos_z = rand_word(); p.pos_r = rand_word();
    p.vel_z = rand_word(); p.vel_r = rand_word(); p.vel_y = rand_word();
    p.field_ez = rand_field(); p.field_er = rand_field();
    p.field_bz = rand_field(); p.field_br = rand_field();
    p.last_particle = $urandom_range(7) == 0;
    return p;
  endfunction

  function automatic in_t flat_particle(fix_t v, fix_t f, logic last);
    in_t p;
    p.pos_z = v; p.pos_r = v; p.vel_z = v; p.vel_r = v; p.vel_y = v;
    p.field_ez = f; p.field_er = f; p.field_bz = f; p.field_br = f;
    p.last_particle = last;
    return p;
  endfunction

  // Wait until every queued particle has been pushed and checked, then drain.
  task automatic wait_drained();
    while (particle_q.size() != 0 || pushed_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  // Write one register at a falling edge, hold until ready at a rising edge.
  task automatic write_reg(bpprz_pkg::cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bpprz_pkg::CFG_TIME_STEP:        dt_q   = data[30:0];
      bpprz_pkg::CFG_CHARGE_OVER_MASS: qm_q   = data;
      bpprz_pkg::CFG_AXIS_RADIUS:      axis_q = data[30:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] dt, logic [31:0] qm, logic [31:0] axis);
    write_reg(bpprz_pkg::CFG_TIME_STEP, dt);
    write_reg(bpprz_pkg::CFG_CHARGE_OVER_MASS, qm);
    write_reg(bpprz_pkg::CFG_AXIS_RADIUS, axis);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    errors = 0; quiet_send = 0; hold_count = 0; idle_cycles = 0;
    dt_q = bpprz_pkg::DT_RST; qm_q = bpprz_pkg::QM_RST; axis_q = bpprz_pkg::AXIS_RST;
    rst_ni = 1'b0; start_i = 1'b0; item_i = '0; taken = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = bpprz_pkg::CFG_TIME_STEP; cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, zero fields, near-axis and huge values at reset setting.
    particle_q.push_back(flat_particle('0, '0, 1'b0));
    particle_q.push_back(flat_particle(bpprz_pkg::FIX_MAX, bpprz_pkg::FIX_MAX, 1'b1));
    particle_q.push_back(flat_particle(bpprz_pkg::FIX_MIN, bpprz_pkg::FIX_MIN, 1'b0));
    particle_q.push_back(flat_particle(bpprz_pkg::FIX_ONE, bpprz_pkg::FIX_ONE, 1'b1));
    particle_q.push_back(flat_particle(-bpprz_pkg::FIX_ONE, bpprz_pkg::FIX_MAX, 1'b0));
    particle_q.push_back(flat_particle(32'sh0000_0001, bpprz_pkg::FIX_MIN, 1'b0));
    particle_q.push_back(flat_particle(32'shFFFF_FFFF, 32'sh0000_8000, 1'b1));
    for (int i = 0; i < 6; i++) particle_q.push_back(rand_particle());
    wait_drained();

    // Axis radius large enough that every radius is near the axis; odd dt.
    set_regs(32'h0000_FFFF, 32'hFFFF_0000, 32'h7FFF_FFFF);
    particle_q.push_back(flat_particle(bpprz_pkg::FIX_ONE, bpprz_pkg::FIX_ONE, 1'b0));
    particle_q.push_back(flat_particle(bpprz_pkg::FIX_MIN, bpprz_pkg::FIX_MAX, 1'b1));
    for (int i = 0; i < 6; i++) particle_q.push_back(rand_particle());
    wait_drained();

    // Register extremes; dt wide masks the top bit.
    set_regs(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    particle_q.push_back(flat_particle(bpprz_pkg::FIX_ONE, bpprz_pkg::FIX_ONE, 1'b0));
    for (int i = 0; i < 5; i++) particle_q.push_back(rand_particle());
    wait_drained();

    set_regs(32'h0000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    for (int i = 0; i < 5; i++) particle_q.push_back(rand_particle());
    wait_drained();

    // Random phases, each with a fresh register setting.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase % 3)
        0: set_regs(32'($urandom_range(4 * 65536)), 32'(int'($urandom_range(8 * 65536)) - 4 * 65536),
                    32'($urandom_range(65536)));
        1: set_regs($urandom(), $urandom(), $urandom());
        default: set_regs(32'(65536 >> $urandom_range(6)), 32'd65536, 32'd0);
      endcase
      quiet_send = (phase == 3);
      for (int i = 0; i < N_RANDOM / 7; i++) begin
        particle_q.push_back(rand_particle());
        // pause the sender until the pipeline has emptied, once per phase
        if (i == 100) begin
          while (particle_q.size() != 0) @(posedge clk_i);
          hold_count = 1;
          while (pushed_q.size() != 0) @(posedge clk_i);
          hold_count = 0;
        end
      end
      wait_drained();
    end
    quiet_send = 0;

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
